/* src/ppm_p6_stream_parser_macros.svh */
// Assertion macros used by the checker of the PPM P6 stream parser.
`ifndef PPM_P6_STREAM_PARSER_MACROS_SVH
`define PPM_P6_STREAM_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("PPM P6 parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("PPM P6 parser assertion failed");

`endif

/* src/ppm_p6_pkg.sv */
package ppm_p6_pkg;

  localparam logic [32:0] NumLimit   = 33'd429496729;
  localparam logic [34:0] MaxPixels  = 35'd1073741823;
  localparam logic [28:0] MaxvalReq  = 29'd255;
  localparam logic [7:0]  ChP        = 8'h50;
  localparam logic [7:0]  Ch6        = 8'h36;
  localparam logic [7:0]  ChHash     = 8'h23;
  localparam logic [7:0]  ChZero     = 8'h30;
  localparam logic [7:0]  ChNine     = 8'h39;
  localparam logic [7:0]  ChLf       = 8'h0a;
  localparam logic [7:0]  ChCr       = 8'h0d;

  typedef enum logic [2:0] {
    PH_MAGIC_P,
    PH_MAGIC_6,
    PH_MAGIC_SP,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXVAL,
    PH_PIXELS,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_PIXEL,
    KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_MAGIC,
    ERR_NO_DIGIT,
    ERR_OVERFLOW,
    ERR_MAXVAL,
    ERR_SEPARATOR,
    ERR_ZERO,
    ERR_TOO_MANY,
    ERR_SHORT
  } err_e;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_HEADER,
    EV_PIXEL,
    EV_ERROR
  } event_e;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] pixel_rgb;
    logic [28:0] width;
    logic [28:0] height;
    logic [2:0]  error_code;
    logic        last_pixel;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == ChCr) || (c == ChLf) ||
           (c == 8'h0c) || (c == 8'h0b);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic err_e eof_code(input phase_e ph, input logic digit,
                                    input logic [28:0] acc);
    err_e code;
    if (ph == PH_MAGIC_P || ph == PH_MAGIC_6 || ph == PH_MAGIC_SP) begin
      code = ERR_MAGIC;
    end else if (!digit || ph != PH_MAXVAL) begin
      code = ERR_NO_DIGIT;
    end else if (acc != MaxvalReq) begin
      code = ERR_MAXVAL;
    end else begin
      code = ERR_SEPARATOR;
    end
    return code;
  endfunction

endpackage

/* src/ppm_p6_core.sv */
module ppm_p6_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        byte_value_i,
  input  logic [31:0]       bytes_total_i,
  output logic              res_valid_o,
  output ppm_p6_pkg::res_t  res_o
);
  import ppm_p6_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [28:0] acc_q, acc_d;
  logic        digit_q, digit_d;
  logic        comment_q, comment_d;
  logic [28:0] width_q, width_d;
  logic [28:0] height_q, height_d;
  logic [29:0] left_q, left_d;
  logic [1:0]  chan_q, chan_d;
  logic [15:0] rg_q, rg_d;
  logic [29:0] prod_q, prod_d;
  logic        big_q, big_d;

  event_e      ev;
  err_e        err;
  logic        cont;
  logic [3:0]  dig;
  logic [32:0] acc_x;
  logic [32:0] wd;
  logic [34:0] prod_x;
  logic [31:0] rem;
  logic [31:0] need;

  always_comb begin
    dig   = byte_value_i[3:0] - ChZero[3:0];
    acc_x = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {29'b0, dig};
    wd    = (dig[0] ? {4'b0, width_q} : 33'd0) + (dig[1] ? {3'b0, width_q, 1'b0} : 33'd0) +
            (dig[2] ? {2'b0, width_q, 2'b0} : 33'd0) + (dig[3] ? {1'b0, width_q, 3'b0} : 33'd0);
    prod_x = ({5'b0, prod_q} << 3) + ({5'b0, prod_q} << 1) + {2'b0, wd};
    rem    = (bytes_total_i > pos_d) ? (bytes_total_i - pos_d) : 32'd0;
    need   = ({2'b0, prod_q} << 1) + {2'b0, prod_q};
  end

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    acc_d     = acc_q;
    digit_d   = digit_q;
    comment_d = comment_q;
    width_d   = width_q;
    height_d  = height_q;
    left_d    = left_q;
    chan_d    = chan_q;
    rg_d      = rg_q;
    prod_d    = prod_q;
    big_d     = big_q;
    ev        = EV_NONE;
    err       = ERR_MAGIC;
    cont      = 1'b0;
    case (phase_q)
      PH_DONE: begin
      end
      PH_PIXELS: begin
        if (chan_q < 2'd2) begin
          rg_d   = {rg_q[7:0], byte_value_i};
          chan_d = chan_q + 2'd1;
        end else begin
          chan_d = 2'd0;
          left_d = left_q - 30'd1;
          ev     = EV_PIXEL;
          if (left_q == 30'd1) begin
            phase_d = PH_DONE;
          end
        end
      end
      default: begin
        if (pos_q >= bytes_total_i) begin
          ev  = EV_ERROR;
          err = eof_code(phase_q, digit_q, acc_q);
        end else begin
          if (pos_q != 32'hffff_ffff) begin
            pos_d = pos_q + 32'd1;
          end
          case (phase_q)
            PH_MAGIC_P: begin
              if (byte_value_i == ChP) begin
                phase_d = PH_MAGIC_6;
              end else begin
                ev = EV_ERROR;
              end
            end
            PH_MAGIC_6: begin
              if (byte_value_i == Ch6) begin
                phase_d = PH_MAGIC_SP;
              end else begin
                ev = EV_ERROR;
              end
            end
            PH_MAGIC_SP: begin
              if (is_ws(byte_value_i)) begin
                phase_d   = PH_WIDTH;
                digit_d   = 1'b0;
                comment_d = 1'b0;
                acc_d     = 29'd0;
              end else begin
                ev = EV_ERROR;
              end
            end
            default: begin
              cont = 1'b1;
              if (digit_q) begin
                if (is_dec(byte_value_i)) begin
                  cont = 1'b0;
                  if (acc_x > NumLimit) begin
                    ev  = EV_ERROR;
                    err = ERR_OVERFLOW;
                  end else begin
                    acc_d = acc_x[28:0];
                    if (phase_q == PH_HEIGHT && !big_q) begin
                      if (prod_x > MaxPixels) begin
                        big_d = 1'b1;
                      end else begin
                        prod_d = prod_x[29:0];
                      end
                    end
                  end
                end else if (phase_q == PH_MAXVAL) begin
                  cont = 1'b0;
                  ev   = EV_ERROR;
                  if (acc_q != MaxvalReq) begin
                    err = ERR_MAXVAL;
                  end else if (!is_ws(byte_value_i)) begin
                    err = ERR_SEPARATOR;
                  end else if (width_q == 29'd0 || height_q == 29'd0) begin
                    err = ERR_ZERO;
                  end else if (big_q) begin
                    err = ERR_TOO_MANY;
                  end else if (need > rem) begin
                    err = ERR_SHORT;
                  end else begin
                    ev      = EV_HEADER;
                    left_d  = prod_q;
                    chan_d  = 2'd0;
                    rg_d    = 16'd0;
                    phase_d = PH_PIXELS;
                  end
                end else begin
                  if (phase_q == PH_WIDTH) begin
                    width_d = acc_q;
                    phase_d = PH_HEIGHT;
                  end else begin
                    height_d = acc_q;
                    phase_d  = PH_MAXVAL;
                  end
                  digit_d   = 1'b0;
                  comment_d = 1'b0;
                  acc_d     = 29'd0;
                end
              end
              if (cont) begin
                if (comment_q && digit_q == 1'b0) begin
                  if (byte_value_i == ChLf || byte_value_i == ChCr) begin
                    comment_d = 1'b0;
                  end
                end else if (is_ws(byte_value_i)) begin
                end else if (byte_value_i == ChHash) begin
                  comment_d = 1'b1;
                end else if (is_dec(byte_value_i)) begin
                  digit_d = 1'b1;
                  acc_d   = {25'd0, dig};
                  if (phase_d == PH_HEIGHT) begin
                    big_d  = wd > 33'(MaxPixels);
                    prod_d = wd[29:0];
                  end
                end else begin
                  ev  = EV_ERROR;
                  err = ERR_NO_DIGIT;
                end
              end
            end
          endcase
          if (ev == EV_NONE && pos_d >= bytes_total_i &&
              (phase_d == PH_MAGIC_P || phase_d == PH_MAGIC_6 ||
               phase_d == PH_MAGIC_SP || phase_d == PH_WIDTH ||
               phase_d == PH_HEIGHT || phase_d == PH_MAXVAL)) begin
            ev  = EV_ERROR;
            err = eof_code(phase_d, digit_d, acc_d);
          end
        end
        if (ev == EV_ERROR) begin
          phase_d = PH_DONE;
        end
      end
    endcase
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    case (ev)
      EV_HEADER: begin
        res_valid_o  = 1'b1;
        res_o.kind   = KIND_HEADER;
        res_o.width  = width_q;
        res_o.height = height_q;
      end
      EV_PIXEL: begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_PIXEL;
        res_o.pixel_rgb  = {rg_q, byte_value_i};
        res_o.last_pixel = (left_q == 30'd1);
      end
      EV_ERROR: begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = err;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC_P;
      pos_q     <= '0;
      acc_q     <= '0;
      digit_q   <= 1'b0;
      comment_q <= 1'b0;
      width_q   <= '0;
      height_q  <= '0;
      left_q    <= '0;
      chan_q    <= '0;
      rg_q      <= '0;
      prod_q    <= '0;
      big_q     <= 1'b0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      acc_q     <= acc_d;
      digit_q   <= digit_d;
      comment_q <= comment_d;
      width_q   <= width_d;
      height_q  <= height_d;
      left_q    <= left_d;
      chan_q    <= chan_d;
      rg_q      <= rg_d;
      prod_q    <= prod_d;
      big_q     <= big_d;
    end
  end

endmodule

/* src/ppm_p6_out_reg.sv */
module ppm_p6_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_valid_i,
  input  ppm_p6_pkg::res_t  res_i,
  input  logic              out_stall_i,
  output logic              busy_o,
  output logic              out_valid_o,
  output ppm_p6_pkg::res_t  res_o
);
  import ppm_p6_pkg::*;

  logic valid_q;
  res_t data_q;

  assign busy_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!busy_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_o && load_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

/* src/ppm_p6_stream_parser.sv */
// PPM P6 stream parser.
// Each input transaction carries one byte of a binary PPM file and the total
// file length, which the user must keep the same for one file (not checked).
// The output channel carries at most one result per input byte: a header
// result with width and height, one packed 0xRRGGBB word per pixel with the
// final pixel marked, or a single error code. After the last pixel or an
// error, all further bytes are accepted and produce no result until reset.
// Each byte is parsed in the cycle it is accepted, and its result is valid
// in the output register on the following cycle. One byte is accepted per
// cycle while the output side does not stall; the output register sets
// that rate.
// When the receiver stalls with a result waiting, in_stall_o rises in the
// same cycle and the waiting result holds until it is taken.
// Reset returns the parser to expect the magic number and empties the
// output register; no clearing pass is needed.
module ppm_p6_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic [31:0] bytes_total_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [23:0] pixel_rgb_o,
  output logic [28:0] width_o,
  output logic [28:0] height_o,
  output logic [2:0]  error_code_o,
  output logic        last_pixel_o
);
  import ppm_p6_pkg::*;

  logic take;
  logic res_valid;
  logic busy;
  res_t res;
  res_t out_res;

  assign in_stall_o = busy;
  assign take       = in_valid_i && !busy;

  ppm_p6_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .byte_value_i  (byte_value_i),
    .bytes_total_i (bytes_total_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  ppm_p6_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (take && res_valid),
    .res_i        (res),
    .out_stall_i  (out_stall_i),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .res_o        (out_res)
  );

  assign kind_o       = out_res.kind;
  assign pixel_rgb_o  = out_res.pixel_rgb;
  assign width_o      = out_res.width;
  assign height_o     = out_res.height;
  assign error_code_o = out_res.error_code;
  assign last_pixel_o = out_res.last_pixel;

endmodule

/* src/ppm_p6_checker.sv */
`include "ppm_p6_stream_parser_macros.svh"

module ppm_p6_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [23:0] pixel_rgb_o,
  input logic [2:0]  error_code_o,
  input logic        last_pixel_o
);
  import ppm_p6_pkg::*;

  logic out_done;

  assign out_done = out_valid_o && !out_stall_i &&
                    (kind_o == KIND_ERROR || (kind_o == KIND_PIXEL && last_pixel_o));

  `PPM_ASSERT_NEXT(a_held_result, out_valid_o && out_stall_i, out_valid_o)
  `PPM_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  `PPM_ASSERT_NEXT(a_silent_after_end, out_done, !out_valid_o)
  `PPM_ASSERT_SAME(a_header_clean, out_valid_o && kind_o == KIND_HEADER,
                   pixel_rgb_o == 24'd0 && error_code_o == 3'd0 && !last_pixel_o)

endmodule

bind ppm_p6_stream_parser ppm_p6_checker u_ppm_p6_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .pixel_rgb_o  (pixel_rgb_o),
  .error_code_o (error_code_o),
  .last_pixel_o (last_pixel_o)
);
